>>> rtl/rotation_matrix_to_quaternion_assert.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by the port checker; depends on nothing else.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Checked only while the block is out of reset.
`define RMQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("rmq port check failed");

// Checked at every edge, reset included.
`define RMQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("rmq port check failed");

`endif

>>> rtl/rmq_pkg.sv
// Shared constants and helpers for the rotation matrix to quaternion block.
// Depends on nothing; used by the top level, the divider cell and the checkers.
package rmq_pkg;

    // Field widths, lane count and default number of fraction bits.
    localparam int ELEM_W        = 16;
    localparam int MAG_W         = 17;
    localparam int NLANE         = 4;
    localparam int FRAC_BITS_DEF = 14;

    // Branch codes.
    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_COL0  = 2'd1;
    localparam logic [1:0] BR_COL1  = 2'd2;
    localparam logic [1:0] BR_COL2  = 2'd3;

    // Lane numbers of the quaternion components.
    localparam logic [1:0] LANE_X = 2'd0;
    localparam logic [1:0] LANE_Y = 2'd1;
    localparam logic [1:0] LANE_Z = 2'd2;
    localparam logic [1:0] LANE_W = 2'd3;

    // The component that takes s/4 on each branch.
    function automatic logic [1:0] path_lane(input logic [1:0] br);
        logic [1:0] ln;
        unique case (br)
            BR_TRACE: ln = LANE_W;
            BR_COL0:  ln = LANE_X;
            BR_COL1:  ln = LANE_Y;
            default:  ln = LANE_Z;
        endcase
        return ln;
    endfunction

endpackage

>>> rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion converter, one matrix per clock cycle.
// A new matrix is taken every cycle that m_ready (or an empty output register)
// allows; each beat passes the input register, the sqrt cells, the divider setup
// register, the divider cells and the output register, where RTW = (max(FRAC_BITS,17)
// + 2 + FRAC_BITS + 1) / 2 root bits are settled one per sqrt cell and NW =
// FRAC_BITS + 18 quotient bits one per divider cell. The whole pipeline stalls
// together while a finished result waits at the output.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [15:0]        s_r00,
    input  logic signed [15:0]        s_r01,
    input  logic signed [15:0]        s_r02,
    input  logic signed [15:0]        s_r10,
    input  logic signed [15:0]        s_r11,
    input  logic signed [15:0]        s_r12,
    input  logic signed [15:0]        s_r20,
    input  logic signed [15:0]        s_r21,
    input  logic signed [15:0]        s_r22,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [15:0]        m_quat_x,
    output logic signed [15:0]        m_quat_y,
    output logic signed [15:0]        m_quat_z,
    output logic signed [15:0]        m_quat_w,
    output logic [1:0]                m_branch_taken,
    output logic                      m_bad_input
);

    localparam int F    = FRAC_BITS;
    localparam int RW   = ((F > 17) ? F : 17) + 2;
    localparam int RTW  = (RW + F + 1) / 2;
    localparam int XW   = 2 * RTW;
    localparam int MW   = rmq_pkg::MAG_W;
    localparam int NL   = rmq_pkg::NLANE;
    localparam int NW   = MW + F + 1;
    localparam int SDW  = RTW + 1;
    localparam int SQSW = 3 + NL + NL * MW;
    localparam int DVSW = 3 + NL + RTW;
    localparam logic signed [RW:0] ONE_S = (RW + 1)'(longint'(1) << F);

    logic en;

    // ---------------- Stage 0: branch choice and radicand ----------------
    logic signed [RW:0] e00, e11, e22;
    logic signed [RW:0] rad_trace, rad_sel;
    logic [1:0]         br;
    logic               bad;
    logic [RW-1:0]      rad_u;
    logic signed [MW-1:0] d [NL];
    logic [MW-1:0]      mag [NL];
    logic [NL-1:0]      sgn;
    logic [SQSW-1:0]    side0;

    always_comb begin
        e00       = (RW + 1)'(s_r00);
        e11       = (RW + 1)'(s_r11);
        e22       = (RW + 1)'(s_r22);
        rad_trace = ONE_S + e00 + e11 + e22;
        for (int k = 0; k < NL; k++) begin
            d[k] = '0;
        end
        if (rad_trace > 0) begin
            br                = rmq_pkg::BR_TRACE;
            rad_sel           = rad_trace;
            d[rmq_pkg::LANE_X] = MW'(s_r21) - MW'(s_r12);
            d[rmq_pkg::LANE_Y] = MW'(s_r02) - MW'(s_r20);
            d[rmq_pkg::LANE_Z] = MW'(s_r10) - MW'(s_r01);
        end else if (s_r00 > s_r11 && s_r00 > s_r22) begin
            br                = rmq_pkg::BR_COL0;
            rad_sel           = ONE_S + e00 - e11 - e22;
            d[rmq_pkg::LANE_Y] = MW'(s_r01) + MW'(s_r10);
            d[rmq_pkg::LANE_Z] = MW'(s_r02) + MW'(s_r20);
            d[rmq_pkg::LANE_W] = MW'(s_r21) - MW'(s_r12);
        end else if (s_r11 > s_r22) begin
            br                = rmq_pkg::BR_COL1;
            rad_sel           = ONE_S + e11 - e00 - e22;
            d[rmq_pkg::LANE_X] = MW'(s_r01) + MW'(s_r10);
            d[rmq_pkg::LANE_Z] = MW'(s_r12) + MW'(s_r21);
            d[rmq_pkg::LANE_W] = MW'(s_r02) - MW'(s_r20);
        end else begin
            br                = rmq_pkg::BR_COL2;
            rad_sel           = ONE_S + e22 - e00 - e11;
            d[rmq_pkg::LANE_X] = MW'(s_r02) + MW'(s_r20);
            d[rmq_pkg::LANE_Y] = MW'(s_r12) + MW'(s_r21);
            d[rmq_pkg::LANE_W] = MW'(s_r10) - MW'(s_r01);
        end
        // A radicand that is not positive is clamped to one LSB.
        bad   = (rad_sel <= 0);
        rad_u = bad ? RW'(1) : rad_sel[RW-1:0];
        for (int k = 0; k < NL; k++) begin
            sgn[k] = d[k][MW-1];
            mag[k] = sgn[k] ? MW'(-d[k]) : MW'(d[k]);
        end
        side0 = {bad, br, sgn, mag[3], mag[2], mag[1], mag[0]};
    end

    logic            v0_reg;
    logic [XW-1:0]   x0_reg;
    logic [SQSW-1:0] side0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg    <= XW'(rad_u) << F;
            side0_reg <= side0;
        end
    end

    // ---------------- Square root chain ----------------
    logic            sq_v    [RTW+1];
    logic [XW-1:0]   sq_x    [RTW+1];
    logic [RTW:0]    sq_rem  [RTW+1];
    logic [RTW-1:0]  sq_root [RTW+1];
    logic [SQSW-1:0] sq_side [RTW+1];

    assign sq_v[0]    = v0_reg;
    assign sq_x[0]    = x0_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = side0_reg;

    for (genvar i = 0; i < RTW; i++) begin : g_sqrt
        rmq_sqrt_cell #(.RTW(RTW), .SW(SQSW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .v_in     (sq_v[i]),
            .x_in     (sq_x[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_in  (sq_side[i]),
            .v_reg    (sq_v[i+1]),
            .x_reg    (sq_x[i+1]),
            .rem_reg  (sq_rem[i+1]),
            .root_reg (sq_root[i+1]),
            .side_reg (sq_side[i+1])
        );
    end

    // ---------------- Divider setup: s, s/4 and rounded dividends ----------------
    logic [RTW-1:0]  root_f;
    logic [MW-1:0]   mag_f [NL];
    logic [RTW:0]    quarter_w;
    logic            pv_reg;
    logic [SDW-1:0]  ps_reg;
    logic [NW-1:0]   pn_reg [NL];
    logic [DVSW-1:0] pside_reg;

    always_comb begin
        root_f = sq_root[RTW];
        for (int k = 0; k < NL; k++) begin
            mag_f[k] = sq_side[RTW][k*MW +: MW];
        end
        quarter_w = ((RTW + 1)'(root_f) + (RTW + 1)'(1)) >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= sq_v[RTW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ps_reg    <= {root_f, 1'b0};
            pside_reg <= {sq_side[RTW][SQSW-1:NL*MW], quarter_w[RTW-1:0]};
            for (int k = 0; k < NL; k++) begin
                // Adding s/2 makes the truncating divide round to nearest.
                pn_reg[k] <= (NW'(mag_f[k]) << F) + NW'(root_f);
            end
        end
    end

    // ---------------- Divider chain ----------------
    logic            dv_v    [NW+1];
    logic [SDW-1:0]  dv_s    [NW+1];
    logic [NW-1:0]   dv_n    [NW+1][NL];
    logic [SDW-1:0]  dv_rem  [NW+1][NL];
    logic [NW-1:0]   dv_q    [NW+1][NL];
    logic [DVSW-1:0] dv_side [NW+1];

    assign dv_v[0]    = pv_reg;
    assign dv_s[0]    = ps_reg;
    assign dv_side[0] = pside_reg;
    for (genvar k = 0; k < NL; k++) begin : g_dv0
        assign dv_n[0][k]   = pn_reg[k];
        assign dv_rem[0][k] = '0;
        assign dv_q[0][k]   = '0;
    end

    for (genvar i = 0; i < NW; i++) begin : g_div
        rmq_div_cell #(.NW(NW), .SDW(SDW), .SW(DVSW)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .v_in     (dv_v[i]),
            .s_in     (dv_s[i]),
            .n_in     (dv_n[i]),
            .rem_in   (dv_rem[i]),
            .q_in     (dv_q[i]),
            .side_in  (dv_side[i]),
            .v_reg    (dv_v[i+1]),
            .s_reg    (dv_s[i+1]),
            .n_reg    (dv_n[i+1]),
            .rem_reg  (dv_rem[i+1]),
            .q_reg    (dv_q[i+1]),
            .side_reg (dv_side[i+1])
        );
    end

    // ---------------- Sign, saturation and output register ----------------
    logic [RTW-1:0]    quarter_f;
    logic [NL-1:0]     sgn_f;
    logic [1:0]        br_f;
    logic              bad_f;
    logic [1:0]        plane;
    logic [RTW+15:0]   quarter_e;
    logic [15:0]       quarter_sat;
    logic [15:0]       comp [NL];

    always_comb begin
        quarter_f   = dv_side[NW][RTW-1:0];
        sgn_f       = dv_side[NW][RTW +: NL];
        br_f        = dv_side[NW][RTW+NL +: 2];
        bad_f       = dv_side[NW][DVSW-1];
        plane       = rmq_pkg::path_lane(br_f);
        quarter_e   = (RTW + 16)'(quarter_f);
        quarter_sat = (quarter_e > (RTW + 16)'(32767)) ? 16'h7fff : quarter_e[15:0];
        for (int k = 0; k < NL; k++) begin
            if (plane == 2'(k)) begin
                comp[k] = quarter_sat;
            end else if (!sgn_f[k]) begin
                comp[k] = (dv_q[NW][k] > NW'(32767)) ? 16'h7fff : dv_q[NW][k][15:0];
            end else begin
                comp[k] = (dv_q[NW][k] > NW'(32768)) ? 16'h8000 : 16'(-dv_q[NW][k][15:0]);
            end
        end
    end

    logic              m_valid_reg;
    logic [15:0]       qx_reg, qy_reg, qz_reg, qw_reg;
    logic [1:0]        br_reg;
    logic              bad_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_v[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg  <= comp[rmq_pkg::LANE_X];
            qy_reg  <= comp[rmq_pkg::LANE_Y];
            qz_reg  <= comp[rmq_pkg::LANE_Z];
            qw_reg  <= comp[rmq_pkg::LANE_W];
            br_reg  <= br_f;
            bad_reg <= bad_f;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_quat_x       = signed'(qx_reg);
    assign m_quat_y       = signed'(qy_reg);
    assign m_quat_z       = signed'(qz_reg);
    assign m_quat_w       = signed'(qw_reg);
    assign m_branch_taken = br_reg;
    assign m_bad_input    = bad_reg;

endmodule

>>> rtl/rmq_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per beat.
// Depends on rmq_pkg only through the top level's parameters.
module rmq_sqrt_cell #(
    parameter int RTW = 17,
    parameter int SW  = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              v_in,
    input  logic [2*RTW-1:0]  x_in,
    input  logic [RTW:0]      rem_in,
    input  logic [RTW-1:0]    root_in,
    input  logic [SW-1:0]     side_in,
    output logic              v_reg,
    output logic [2*RTW-1:0]  x_reg,
    output logic [RTW:0]      rem_reg,
    output logic [RTW-1:0]    root_reg,
    output logic [SW-1:0]     side_reg
);

    logic [RTW+1:0] trial;
    logic [RTW+2:0] diff;
    logic           ge;
    logic [RTW:0]   rem_next;
    logic [RTW-1:0] root_next;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        trial     = {rem_in[RTW-1:0], x_in[2*RTW-1:2*RTW-2]};
        diff      = {1'b0, trial} - {1'b0, root_in, 2'b01};
        ge        = !diff[RTW+2];
        rem_next  = ge ? diff[RTW:0] : trial[RTW:0];
        root_next = {root_in[RTW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= {x_in[2*RTW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

endmodule

>>> rtl/rmq_div_cell.sv
// One cell of the divider chain: one quotient bit per beat on all four lanes.
// Depends on rmq_pkg for the lane count.
module rmq_div_cell #(
    parameter int NW  = 32,
    parameter int SDW = 18,
    parameter int SW  = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           v_in,
    input  logic [SDW-1:0] s_in,
    input  logic [NW-1:0]  n_in   [rmq_pkg::NLANE],
    input  logic [SDW-1:0] rem_in [rmq_pkg::NLANE],
    input  logic [NW-1:0]  q_in   [rmq_pkg::NLANE],
    input  logic [SW-1:0]  side_in,
    output logic           v_reg,
    output logic [SDW-1:0] s_reg,
    output logic [NW-1:0]  n_reg   [rmq_pkg::NLANE],
    output logic [SDW-1:0] rem_reg [rmq_pkg::NLANE],
    output logic [NW-1:0]  q_reg   [rmq_pkg::NLANE],
    output logic [SW-1:0]  side_reg
);

    logic [SDW:0]   trial [rmq_pkg::NLANE];
    logic [SDW+1:0] diff  [rmq_pkg::NLANE];
    logic           ge    [rmq_pkg::NLANE];

    // Shift in the next dividend bit and subtract the divisor where it fits.
    always_comb begin
        for (int k = 0; k < rmq_pkg::NLANE; k++) begin
            trial[k] = {rem_in[k], n_in[k][NW-1]};
            diff[k]  = {1'b0, trial[k]} - {2'b00, s_in};
            ge[k]    = !diff[k][SDW+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg    <= s_in;
            side_reg <= side_in;
            for (int k = 0; k < rmq_pkg::NLANE; k++) begin
                n_reg[k]   <= {n_in[k][NW-2:0], 1'b0};
                rem_reg[k] <= ge[k] ? diff[k][SDW-1:0] : trial[k][SDW-1:0];
                q_reg[k]   <= {q_in[k][NW-2:0], ge[k]};
            end
        end
    end

endmodule

>>> rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion block, bound to
// the top level. Depends on rmq_pkg and rotation_matrix_to_quaternion_assert.svh.
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_quat_x,
    input logic signed [15:0] m_quat_y,
    input logic signed [15:0] m_quat_z,
    input logic signed [15:0] m_quat_w,
    input logic [1:0]         m_branch_taken,
    input logic               m_bad_input
);

    // A stalled result beat holds its x and w components and its branch code.
    `RMQ_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_quat_x) && $stable(m_quat_w) && $stable(m_branch_taken))

    // The input side stalls exactly when a result is stuck at the output.
    `RMQ_ASSERT(a_in_stall, s_ready == (!m_valid || m_ready))

    // The trace path never clamps its radicand and gives a nonnegative w.
    `RMQ_ASSERT(a_trace_ok, m_valid && m_branch_taken == rmq_pkg::BR_TRACE |-> !m_bad_input && !m_quat_w[15])

    // The column 0 path gives a nonnegative value in its own component, x.
    `RMQ_ASSERT(a_col_ok, m_valid && m_branch_taken == rmq_pkg::BR_COL0 |-> !m_quat_x[15])

    // Reset empties the output.
    `RMQ_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_valid)

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

>>> tb/rotation_matrix_to_quaternion_checker.sv
// Checker for the rotation matrix to quaternion converter: watches both channels,
// predicts each quaternion from the accepted matrix and compares field by field.
// Depends on rmq_pkg for the branch codes.
module rotation_matrix_to_quaternion_checker #(
    parameter int FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [15:0] s_r00, s_r01, s_r02,
    input  logic signed [15:0] s_r10, s_r11, s_r12,
    input  logic signed [15:0] s_r20, s_r21, s_r22,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_quat_x, m_quat_y, m_quat_z, m_quat_w,
    input  logic [1:0]         m_branch_taken,
    input  logic               m_bad_input,
    output int                 err_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] qx, qy, qz, qw;
        logic [1:0]         branch;
        logic               bad;
    } quat_t;

    quat_t quat_queue[$];

    // Integer square root, floor.
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // Rounded division of (d << FRAC_BITS) by s, ties away from zero.
    function automatic longint scaled_div(input longint d, input longint s);
        longint mag, q;
        mag = (d < 0) ? -d : d;
        q = ((mag <<< FRAC_BITS) + (s >>> 1)) / s;
        return (d < 0) ? -q : q;
    endfunction

    function automatic quat_t convert_matrix(
        input longint a00, a01, a02, a10, a11, a12, a20, a21, a22);
        quat_t r;
        longint one, rad, dx, dy, dz, dw, root, s, quarter;
        one = longint'(1) <<< FRAC_BITS;
        r.bad = 1'b0;
        rad = one + a00 + a11 + a22;
        if (rad > 0) begin
            r.branch = rmq_pkg::BR_TRACE;
            dx = a21 - a12; dy = a02 - a20; dz = a10 - a01; dw = 0;
        end else if (a00 > a11 && a00 > a22) begin
            r.branch = rmq_pkg::BR_COL0;
            rad = one + a00 - a11 - a22;
            dx = 0; dy = a01 + a10; dz = a02 + a20; dw = a21 - a12;
        end else if (a11 > a22) begin
            r.branch = rmq_pkg::BR_COL1;
            rad = one + a11 - a00 - a22;
            dx = a01 + a10; dy = 0; dz = a12 + a21; dw = a02 - a20;
        end else begin
            r.branch = rmq_pkg::BR_COL2;
            rad = one + a22 - a00 - a11;
            dx = a02 + a20; dy = a12 + a21; dz = 0; dw = a10 - a01;
        end
        // A column radicand that is not positive is clamped to one LSB.
        if (rad <= 0) begin
            rad = 1;
            r.bad = 1'b1;
        end
        root = longint'(int_sqrt(longint'(rad) <<< FRAC_BITS));
        s = root * 2;
        quarter = (root + 1) >>> 1;
        r.qx = clamp16(r.branch == rmq_pkg::BR_COL0  ? quarter : scaled_div(dx, s));
        r.qy = clamp16(r.branch == rmq_pkg::BR_COL1  ? quarter : scaled_div(dy, s));
        r.qz = clamp16(r.branch == rmq_pkg::BR_COL2  ? quarter : scaled_div(dz, s));
        r.qw = clamp16(r.branch == rmq_pkg::BR_TRACE ? quarter : scaled_div(dw, s));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    initial begin
        err_count = 0;
        pending   = 0;
    end

    // Predict on each input beat; compare on each output beat.
    always @(posedge aclk) begin
        quat_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                quat_queue.push_back(convert_matrix(s_r00, s_r01, s_r02, s_r10, s_r11,
                                                    s_r12, s_r20, s_r21, s_r22));
            if (m_valid && m_ready) begin
                if (quat_queue.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = quat_queue.pop_front();
                    if (m_quat_x != want.qx) report_mismatch("quat_x", m_quat_x, want.qx);
                    if (m_quat_y != want.qy) report_mismatch("quat_y", m_quat_y, want.qy);
                    if (m_quat_z != want.qz) report_mismatch("quat_z", m_quat_z, want.qz);
                    if (m_quat_w != want.qw) report_mismatch("quat_w", m_quat_w, want.qw);
                    if (m_branch_taken != want.branch)
                        report_mismatch("branch_taken", m_branch_taken, want.branch);
                    if (m_bad_input != want.bad)
                        report_mismatch("bad_input", m_bad_input, want.bad);
                end
            end
        end
        pending = quat_queue.size();
    end
endmodule

>>> tb/rotation_matrix_to_quaternion_tb.sv
// Testbench top for the rotation matrix to quaternion converter: drives matrices
// and output stalls, and gives the verdict. Depends on the block and the checker.
module rotation_matrix_to_quaternion_tb;
    logic               aclk;
    logic               aresetn;
    logic               s_valid, s_ready, m_valid, m_ready;
    logic signed [15:0] s_r00, s_r01, s_r02, s_r10, s_r11, s_r12, s_r20, s_r21, s_r22;
    logic signed [15:0] m_quat_x, m_quat_y, m_quat_z, m_quat_w;
    logic [1:0]         m_branch_taken;
    logic               m_bad_input;
    int                 err_count, pending;
    int                 cycle_count;
    int                 rx_wait;
    bit                 long_hold;

    localparam int RANDOM_ITEMS = 1130;
    localparam int CYCLE_LIMIT  = 400000;

    rotation_matrix_to_quaternion u_dut (.*);

    rotation_matrix_to_quaternion_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Drive one matrix beat after a random gap and wait for acceptance.
    // With no gap the beat follows the previous one directly.
    task automatic send_matrix(input logic signed [15:0] m [9]);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        {s_r00, s_r01, s_r02} <= {m[0], m[1], m[2]};
        {s_r10, s_r11, s_r12} <= {m[3], m[4], m[5]};
        {s_r20, s_r21, s_r22} <= {m[6], m[7], m[8]};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop offering beats and wait until every result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
    endtask

    // Random element: mostly rotation-like magnitudes, sometimes extremes.
    function automatic logic signed [15:0] pick_elem();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Random matrix, sometimes steered toward one of the column branches.
    task automatic random_matrix(output logic signed [15:0] m [9]);
        int k;
        for (int i = 0; i < 9; i++) m[i] = pick_elem();
        k = $urandom_range(0, 3);
        if (k != 0 && $urandom_range(0, 3) != 0) begin
            for (int i = 0; i < 3; i++)
                m[4 * i] = -16'sd16384 + 16'($urandom_range(0, 8000));
            m[4 * (k - 1)] = 16'sd16384 - 16'($urandom_range(0, 8000));
        end
    endtask

    // Output stalls: a random wait after each result beat; one long hold-off
    // is forced from its own process.
    always @(posedge aclk) begin
        int w;
        w = $urandom_range(0, 11);
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            rx_wait <= w;
            m_ready <= (w == 0) && !long_hold;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1) && !long_hold;
        end else begin
            m_ready <= !long_hold;
        end
    end

    initial begin
        long_hold = 1'b0;
        wait (cycle_count == 3000);
        @(posedge aclk);
        long_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        long_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic signed [15:0] mat [9];
        cycle_count = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        {s_r00, s_r01, s_r02, s_r10, s_r11, s_r12, s_r20, s_r21, s_r22} = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: identity, half-turns about each axis, ties, extremes.
        mat = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};           send_matrix(mat);
        mat = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};         send_matrix(mat);
        mat = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};         send_matrix(mat);
        mat = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};         send_matrix(mat);
        mat = '{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384};        send_matrix(mat);
        mat = '{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192};           send_matrix(mat);
        mat = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};        send_matrix(mat);
        mat = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(mat);
        mat = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(mat);
        mat = '{-16384, 32767, -32768, 32767, -16384, 32767, -32768, 32767, -16384};
        send_matrix(mat);
        mat = '{-16384, -32768, 32767, -32768, -16384, -32768, 32767, -32768, 0};
        send_matrix(mat);
        mat = '{-16383, 0, 0, 0, 0, 0, 0, 0, -1};                 send_matrix(mat);
        mat = '{-16384, 100, -200, 300, 0, -400, 500, -600, 0};   send_matrix(mat);
        mat = '{0, 32767, 0, -32768, -16384, 0, 0, 0, -16384};    send_matrix(mat);
        mat = '{-32768, 1, 2, 3, -32768, 5, 6, 7, 32767};         send_matrix(mat);
        mat = '{32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, -32768};
        send_matrix(mat);
        // Let every result drain before the random part.
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            random_matrix(mat);
            send_matrix(mat);
            if (n == 600) drain();
        end

        drain();
        repeat (120) @(posedge aclk);
        if (err_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
